/* rtl/iiea_pkg.sv */
package iiea_pkg;

    localparam int POS_W    = 6;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 6;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_INSERT     = 3'd4,
        CMD_ERASE      = 3'd5,
        CMD_READ       = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [WORD_W-1:0] value;
    } cell_ctrl_t;

endpackage

/* rtl/iiea_req_if.sv */
interface iiea_req_if
    import iiea_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

/* rtl/iiea_rsp_if.sv */
interface iiea_rsp_if
    import iiea_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output read_value, output count, output status,
                    input ready);
    modport sink   (input valid, input read_value, input count, input status,
                    output ready);
endinterface

/* rtl/iiea_cell.sv */
module iiea_cell
    import iiea_pkg::*;
#(
    parameter int IW    = 5,
    parameter int INDEX = 0
) (
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic [IW-1:0]            at,
    input  logic [IW-1:0]            rd_at,
    input  logic signed [WORD_W-1:0] from_lower,
    input  logic signed [WORD_W-1:0] from_upper,
    output logic signed [WORD_W-1:0] q,
    output logic signed [WORD_W-1:0] rd
);

    localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (MY_INDEX == at)
                begin
                    data_next = ctrl.value;
                end
                else if (MY_INDEX > at)
                begin
                    data_next = from_lower;
                end
            end
            OP_REMOVE:
            begin
                if (MY_INDEX >= at)
                begin
                    data_next = from_upper;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q  = data_reg;
    // drive the read bus only when addressed
    assign rd = (rd_at == MY_INDEX) ? data_reg : '0;

endmodule

/* rtl/indexed_insert_erase_array_unit.sv */
// Ordered array of signed words with insert and erase at any index.
// req carries command, position and value; rsp returns read_value, count and
// status, one result item for every command item.
// Commands: push back/front, pop back/front, insert, erase, read. Insert and
// erase shift every later entry by one place; all cells move together.
// The result of an item is registered and shows on rsp in the cycle after it is taken.
// Throughput: one item per cycle while rsp is not stalled, set by the row of
// DEPTH cells that each load, shift from a neighbour or hold in the same edge,
// and the single result register.
// A full array rejects growth with status 1; a bad index, an empty pop or an
// unused command returns status 2 and changes nothing.
// Reset clears the count and the result valid flag; the result register and cell
// contents stay undefined until written, and only written entries can be read.
// When rsp is stalled the result register holds and req.ready drops until
// the result is taken.
module indexed_insert_erase_array_unit
    import iiea_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    iiea_req_if.sink    req,
    iiea_rsp_if.source  rsp
);

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]            used_reg;
    logic [CW-1:0]            used_next;
    logic                     rsp_valid_reg;
    logic signed [WORD_W-1:0] read_value_reg;
    logic signed [WORD_W-1:0] read_value_next;
    logic [COUNT_W-1:0]       count_reg;
    logic [STATUS_W-1:0]      status_reg;
    status_t                  status_next;

    logic                     accept;
    logic [CMPW-1:0]          pos_x;
    logic [CMPW-1:0]          used_x;
    logic                     full;
    logic                     empty;
    cell_ctrl_t               ctrl;
    logic [IW-1:0]            at;
    logic signed [WORD_W-1:0] read_bus;

    logic signed [WORD_W-1:0] cell_q  [DEPTH];
    logic signed [WORD_W-1:0] cell_rd [DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign pos_x  = CMPW'(req.position);
    assign used_x = CMPW'(used_reg);
    assign full   = (used_reg == CW'(DEPTH));
    assign empty  = (used_reg == '0);

    always_comb
    begin
        read_bus = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            read_bus = read_bus | cell_rd[i];
        end
    end

    always_comb
    begin
        ctrl.op         = OP_HOLD;
        ctrl.value      = req.value;
        at              = pos_x[IW-1:0];
        used_next       = used_reg;
        status_next     = ST_OK;
        read_value_next = '0;
        unique case (cmd_t'(req.command))
            CMD_PUSH_BACK:
            begin
                at = used_reg[IW-1:0];
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.op   = OP_INSERT;
                    used_next = used_reg + CW'(1);
                end
            end
            CMD_PUSH_FRONT:
            begin
                at = '0;
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.op   = OP_INSERT;
                    used_next = used_reg + CW'(1);
                end
            end
            CMD_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_BAD;
                end
                else
                begin
                    used_next = used_reg - CW'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                at = '0;
                if (empty)
                begin
                    status_next = ST_BAD;
                end
                else
                begin
                    ctrl.op   = OP_REMOVE;
                    used_next = used_reg - CW'(1);
                end
            end
            CMD_INSERT:
            begin
                if (pos_x > used_x)
                begin
                    status_next = ST_BAD;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.op   = OP_INSERT;
                    used_next = used_reg + CW'(1);
                end
            end
            CMD_ERASE:
            begin
                if (pos_x >= used_x)
                begin
                    status_next = ST_BAD;
                end
                else
                begin
                    ctrl.op   = OP_REMOVE;
                    used_next = used_reg - CW'(1);
                end
            end
            CMD_READ:
            begin
                if (pos_x >= used_x)
                begin
                    status_next = ST_BAD;
                end
                else
                begin
                    read_value_next = read_bus;
                end
            end
            default:
            begin
                status_next = ST_BAD;
            end
        endcase
        // hold every cell unless an item is taken
        if (!accept)
        begin
            ctrl.op = OP_HOLD;
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [WORD_W-1:0] lower;
        logic signed [WORD_W-1:0] upper;

        if (g == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_mid_low
            assign lower = cell_q[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign upper = cell_q[g];
        end
        else
        begin : g_mid_up
            assign upper = cell_q[g+1];
        end

        iiea_cell #(
            .IW    (IW),
            .INDEX (g)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .at         (at),
            .rd_at      (pos_x[IW-1:0]),
            .from_lower (lower),
            .from_upper (upper),
            .q          (cell_q[g]),
            .rd         (cell_rd[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                used_reg      <= used_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg <= read_value_next;
            count_reg      <= COUNT_W'(used_next);
            status_reg     <= status_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.count      = count_reg;
    assign rsp.status     = status_reg;

`ifndef NO_ASSERTIONS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> rsp.valid)
        else $error("taken item produced no result");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(DEPTH))
        else $error("count exceeds capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_FULL |-> rsp.count == COUNT_W'(DEPTH))
        else $error("full status with array not full");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.read_value == '0)
        else $error("failed command returned data");
`endif

endmodule
